### rtl/ea2rm_pkg.sv
// ea2rm_pkg: shared constants, types and functions for the Euler angle to
// rotation matrix core. No dependencies.
`default_nettype none
package ea2rm_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int OUT_BITS_DEF      = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_STAGES        = 32;

    // Q2.30 CORDIC start value (gain compensation)
    localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

    // convention codes
    localparam logic [1:0] CONV_ABG   = 2'd0;
    localparam logic [1:0] CONV_BUNGE = 2'd1;
    localparam logic [1:0] CONV_XZXZ  = 2'd2;
    localparam logic [1:0] CONV_XYZ   = 2'd3;
    localparam logic [1:0] CONV_RESET = CONV_BUNGE;

    // arctangent table, units of 2^-32 turn
    function automatic logic signed [33:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        begin
            unique case (idx)
                5'd0:  v = 32'h20000000;
                5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;
                5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;
                5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;
                5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;
                5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;
                5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;
                5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;
                5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;
                5'd23: v = 32'h00000051;
                5'd24: v = 32'h00000029;
                5'd25: v = 32'h00000014;
                5'd26: v = 32'h0000000A;
                5'd27: v = 32'h00000005;
                5'd28: v = 32'h00000003;
                5'd29: v = 32'h00000001;
                5'd30: v = 32'h00000001;
                default: v = 32'h00000000;
            endcase
            atan_lut = $signed({2'b00, v});
        end
    endfunction

    // Q2.30 product with round half up
    function automatic logic signed [33:0] qmul(input logic signed [33:0] p,
                                                input logic signed [33:0] q);
        logic signed [67:0] pr;
        begin
            pr   = p * q + 68'sd536870912;
            qmul = pr[63:30];
        end
    endfunction

    typedef struct packed {
        logic signed [33:0] s;
        logic signed [33:0] c;
    } sc_t;

endpackage
`default_nettype wire

### rtl/ea2rm_cordic.sv
// ea2rm_cordic: pipelined CORDIC sine/cosine, one register stage per iteration.
// Depends on ea2rm_pkg.
`default_nettype none
module ea2rm_cordic
    import ea2rm_pkg::*;
#(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [ANGLE_BITS-1:0] angle,
    output sc_t                        result
);
    localparam int NST = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

    logic signed [33:0] x_reg [NST+1];
    logic signed [33:0] y_reg [NST+1];
    logic signed [33:0] z_reg [NST+1];
    logic               flip_reg [NST+1];

    logic [31:0] ph;
    logic        flip_in;
    logic [31:0] ph_adj;

    // range reduction into [-pi/2, pi/2)
    always_comb
    begin
        ph      = {angle, {(32-ANGLE_BITS){1'b0}}};
        flip_in = ph[31] ^ ph[30];
        ph_adj  = flip_in ? (ph + 32'h80000000) : ph;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= $signed({{2{ph_adj[31]}}, ph_adj});
            flip_reg[0] <= flip_in;
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < NST; i++)
    begin : g_stage
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [33:0] at;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign at = atan_lut(5'(i));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - at;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + at;
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    assign result.c = flip_reg[NST] ? -x_reg[NST] : x_reg[NST];
    assign result.s = flip_reg[NST] ? -y_reg[NST] : y_reg[NST];
endmodule
`default_nettype wire

### rtl/ea2rm_matrix.sv
// ea2rm_matrix: product, sum and saturation stages forming the nine entries.
// Depends on ea2rm_pkg.
`default_nettype none
module ea2rm_matrix
    import ea2rm_pkg::*;
#(
    parameter int OUT_BITS = OUT_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [1:0]                 conv,
    input  wire sc_t                        a,
    input  wire sc_t                        b,
    input  wire sc_t                        c,
    output logic signed [9*OUT_BITS-1:0]    m
);
    localparam int SH = 31 - OUT_BITS;

    // stage 1: two-factor products
    logic signed [33:0] cacb_reg, casb_reg, sasc_reg, sacc_reg, casc_reg, cacc_reg;
    logic signed [33:0] sbsc_reg, cbsc_reg, sbcc_reg, cbcc_reg, sacb_reg, sasb_reg;
    logic signed [33:0] scsb_reg, ccsb_reg, cbsa_reg, casb2_reg;
    logic signed [33:0] ca1_reg, cb1_reg, sb1_reg, sc1_reg, cc1_reg;
    logic [1:0]         conv1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cacb_reg  <= qmul(a.c, b.c);
            casb_reg  <= qmul(a.c, b.s);
            sasc_reg  <= qmul(a.s, c.s);
            sacc_reg  <= qmul(a.s, c.c);
            casc_reg  <= qmul(a.c, c.s);
            cacc_reg  <= qmul(a.c, c.c);
            sbsc_reg  <= qmul(b.s, c.s);
            cbsc_reg  <= qmul(b.c, c.s);
            sbcc_reg  <= qmul(b.s, c.c);
            cbcc_reg  <= qmul(b.c, c.c);
            sacb_reg  <= qmul(a.s, b.c);
            sasb_reg  <= qmul(a.s, b.s);
            scsb_reg  <= qmul(c.s, b.s);
            ccsb_reg  <= qmul(c.c, b.s);
            cbsa_reg  <= qmul(b.c, a.s);
            casb2_reg <= qmul(c.c, a.s);
            ca1_reg <= a.c;
            cb1_reg <= b.c; sb1_reg <= b.s;
            cc1_reg <= c.c; sc1_reg <= c.s;
            conv1_reg <= conv;
        end
    end

    // stage 2: third factor, left to right, sums formed per convention
    logic signed [35:0] e_next [9];
    logic signed [35:0] e_reg  [9];

    always_comb
    begin
        for (int j = 0; j < 9; j++)
            e_next[j] = '0;
        unique case (conv1_reg)
            CONV_ABG:
            begin
                e_next[0] = 36'(qmul(cacb_reg, cc1_reg)) - 36'(sbsc_reg);
                e_next[1] = 36'(qmul(casb_reg, cc1_reg)) + 36'(cbsc_reg);
                e_next[2] = -36'(sacc_reg);
                e_next[3] = -36'(qmul(cacb_reg, sc1_reg)) - 36'(sbcc_reg);
                e_next[4] = -36'(qmul(casb_reg, sc1_reg)) + 36'(cbcc_reg);
                e_next[5] = 36'(sasc_reg);
                e_next[6] = 36'(sacb_reg);
                e_next[7] = 36'(sasb_reg);
                e_next[8] = 36'(ca1_reg);
            end
            CONV_BUNGE:
            begin
                e_next[0] = 36'(cacc_reg) - 36'(qmul(sasc_reg, cb1_reg));
                e_next[1] = -36'(casc_reg) - 36'(qmul(sacc_reg, cb1_reg));
                e_next[2] = 36'(sasb_reg);
                e_next[3] = 36'(sacc_reg) + 36'(qmul(casc_reg, cb1_reg));
                e_next[4] = -36'(sasc_reg) + 36'(qmul(cacc_reg, cb1_reg));
                e_next[5] = -36'(casb_reg);
                e_next[6] = 36'(scsb_reg);
                e_next[7] = 36'(ccsb_reg);
                e_next[8] = 36'(cb1_reg);
            end
            CONV_XZXZ:
            begin
                // products commute exactly, so reuse the shared terms
                e_next[0] = 36'(cacc_reg) - 36'(qmul(cbsa_reg, sc1_reg));
                e_next[1] = 36'(sacc_reg) + 36'(qmul(cacb_reg, sc1_reg));
                e_next[2] = 36'(scsb_reg);
                e_next[3] = -36'(casc_reg) - 36'(qmul(cbsa_reg, cc1_reg));
                e_next[4] = -36'(sasc_reg) + 36'(qmul(cacb_reg, cc1_reg));
                e_next[5] = 36'(ccsb_reg);
                e_next[6] = 36'(sasb_reg);
                e_next[7] = -36'(casb_reg);
                e_next[8] = 36'(cb1_reg);
            end
            CONV_XYZ:
            begin
                e_next[0] = 36'(cbcc_reg);
                e_next[1] = 36'(qmul(casb2_reg, sb1_reg)) + 36'(casc_reg);
                e_next[2] = 36'(sasc_reg) - 36'(qmul(cacc_reg, sb1_reg));
                e_next[3] = -36'(cbsc_reg);
                e_next[4] = 36'(cacc_reg) - 36'(qmul(sasc_reg, sb1_reg));
                e_next[5] = 36'(qmul(casc_reg, sb1_reg)) + 36'(sacc_reg);
                e_next[6] = 36'(sb1_reg);
                e_next[7] = -36'(cbsa_reg);
                e_next[8] = 36'(cacb_reg);
            end
            default:
            begin
                e_next[0] = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 9; j++)
                e_reg[j] <= e_next[j];
        end
    end

    // stage 3: round and saturate
    localparam logic signed [36:0] HI = 37'sd1 <<< (OUT_BITS - 1);
    logic signed [OUT_BITS-1:0] o_reg [9];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 9; j++)
            begin
                logic signed [36:0] r;
                if (SH > 0)
                    r = (37'(e_reg[j]) + (37'sd1 <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
                else if (SH < 0)
                    r = 37'(e_reg[j]) <<< 1;
                else
                    r = 37'(e_reg[j]);
                if (r > HI - 37'sd1)
                    o_reg[j] <= (OUT_BITS)'(HI - 37'sd1);
                else if (r < -HI)
                    o_reg[j] <= (OUT_BITS)'(-HI);
                else
                    o_reg[j] <= r[OUT_BITS-1:0];
            end
        end
    end

    for (genvar j = 0; j < 9; j++)
    begin : g_out
        assign m[j*OUT_BITS +: OUT_BITS] = o_reg[j];
    end
endmodule
`default_nettype wire

### rtl/euler_angles_to_rotation_matrix_core.sv
// Euler angle triple to 3x3 rotation matrix, fully pipelined.
// Channels: request in (in_valid/in_stall with angle_a..c), result out
// (out_valid/out_stall with m00..m22), and a config write port
// (cfg_valid/cfg_ready/cfg_data) carrying the two-bit convention
// (0 alpha-beta-gamma, 1 Bunge ZXZ, 2 X ZXZ, 3 XYZ). Reset value is 1.
// Pipeline: one input register, N rotation stages and three matrix stages,
// N = CORDIC_STAGES capped at 32.
// Throughput: one request per cycle while the output is not stalled; the
// pipeline length is set by the CORDIC iteration count.
// The whole pipeline advances together; when the receiver stalls with a
// valid result at the output, every stage holds and in_stall is raised,
// so nothing is lost or repeated. Bubbles are not squeezed out: the pipe
// holds whenever the output stage is full and stalled.
// Reset clears the valid bits and sets the convention to Bunge ZXZ.
// Write the convention only while the pipeline is empty.
`default_nettype none
module euler_angles_to_rotation_matrix_core
    import ea2rm_pkg::*;
#(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int OUT_BITS      = OUT_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic signed [ANGLE_BITS-1:0] angle_a,
    input  wire logic signed [ANGLE_BITS-1:0] angle_b,
    input  wire logic signed [ANGLE_BITS-1:0] angle_c,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [OUT_BITS-1:0]       m00,
    output logic signed [OUT_BITS-1:0]       m01,
    output logic signed [OUT_BITS-1:0]       m02,
    output logic signed [OUT_BITS-1:0]       m10,
    output logic signed [OUT_BITS-1:0]       m11,
    output logic signed [OUT_BITS-1:0]       m12,
    output logic signed [OUT_BITS-1:0]       m20,
    output logic signed [OUT_BITS-1:0]       m21,
    output logic signed [OUT_BITS-1:0]       m22,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [1:0]                  cfg_data
);
    localparam int NST = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
    localparam int LAT = NST + 4;

    logic [1:0]     conv_reg;
    logic [LAT-1:0] vld_reg;
    logic           en;
    sc_t            sca, scb, scc;
    logic signed [9*OUT_BITS-1:0] mflat;

    assign en        = !(vld_reg[LAT-1] && out_stall);
    assign in_stall  = !en;
    assign out_valid = vld_reg[LAT-1];
    assign cfg_ready = 1'b1;

    // convention register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            conv_reg <= CONV_RESET;
        else if (cfg_valid && cfg_ready)
            conv_reg <= cfg_data;
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    ea2rm_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_a
    (
        .clk(clk), .en(en), .angle(angle_a), .result(sca)
    );
    ea2rm_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_b
    (
        .clk(clk), .en(en), .angle(angle_b), .result(scb)
    );
    ea2rm_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_c
    (
        .clk(clk), .en(en), .angle(angle_c), .result(scc)
    );

    ea2rm_matrix #(.OUT_BITS(OUT_BITS)) u_matrix
    (
        .clk(clk), .en(en), .conv(conv_reg), .a(sca), .b(scb), .c(scc), .m(mflat)
    );

    assign m00 = mflat[0*OUT_BITS +: OUT_BITS];
    assign m01 = mflat[1*OUT_BITS +: OUT_BITS];
    assign m02 = mflat[2*OUT_BITS +: OUT_BITS];
    assign m10 = mflat[3*OUT_BITS +: OUT_BITS];
    assign m11 = mflat[4*OUT_BITS +: OUT_BITS];
    assign m12 = mflat[5*OUT_BITS +: OUT_BITS];
    assign m20 = mflat[6*OUT_BITS +: OUT_BITS];
    assign m21 = mflat[7*OUT_BITS +: OUT_BITS];
    assign m22 = mflat[8*OUT_BITS +: OUT_BITS];

`ifndef SYNTHESIS
    // a stalled result is held
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(m00) && $stable(m22))
        else $error("result changed under stall");
    // input stall only when output is blocked
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("spurious input stall");
    // pipeline frozen while stalled
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(vld_reg))
        else $error("pipeline moved under stall");
`endif
endmodule
`default_nettype wire
